@@ rtl/ssfl_pkg.sv @@
// ============================================================================
// ssfl_pkg
// shared codes and command types for the size sorted free list
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ssfl_pkg;

    localparam int unsigned FUNC_W = 2;
    localparam int unsigned STAT_W = 2;
    localparam int unsigned WORD_W = 32;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    typedef struct packed {
        logic load_req;
        logic cmp_en;
        logic commit;
    } t_cmd;

endpackage

`default_nettype wire

@@ rtl/ssfl_if.sv @@
// ============================================================================
// ssfl_req_if / ssfl_rsp_if
// request and response channels with valid/ready handshake
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface ssfl_req_if;
    logic                           valid;
    logic                           ready;
    logic [ssfl_pkg::FUNC_W-1:0]    func;
    logic [ssfl_pkg::WORD_W-1:0]    block_addr;
    logic [ssfl_pkg::WORD_W-1:0]    block_size;

    modport source (output valid, func, block_addr, block_size, input ready);
    modport sink   (input valid, func, block_addr, block_size, output ready);
endinterface

interface ssfl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [ssfl_pkg::STAT_W-1:0]    status;
    logic [ssfl_pkg::WORD_W-1:0]    found_addr;
    logic [ssfl_pkg::WORD_W-1:0]    found_size;

    modport source (output valid, status, found_addr, found_size, input ready);
    modport sink   (input valid, status, found_addr, found_size, output ready);
endinterface

`default_nettype wire

@@ rtl/size_sorted_free_list.sv @@
// ============================================================================
// size_sorted_free_list
// table of free heap blocks kept in ascending size order, best fit lookup
// ============================================================================
// usage
//   i_req carries one operation per transaction: insert a block (address,
//   size), remove a block by address, or find the first block whose size
//   covers the request. o_rsp returns one transaction per request with a
//   status and, on a find hit, the address and size of the fitting block.
//   steps: the request is captured at its edge, then every cell compares
//   against it at once, then the whole row shifts and the result loads.
//   the block works on one request at a time: it takes no new request
//   while the compare or a stalled commit is still pending.
//   a new request is taken in the commit cycle, while the previous response
//   may still sit in the output register.
//   reset empties the table at once; entries hold no data until written.
//   when o_rsp is stalled the response holds and the block stops in its
//   commit state until the response is taken.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module size_sorted_free_list #(
    parameter int unsigned DEPTH = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ssfl_req_if.sink    i_req,
    ssfl_rsp_if.source  o_rsp
);

    ssfl_pkg::t_cmd cmd;

    ssfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    ssfl_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_req.func),
        .i_addr       (i_req.block_addr),
        .i_size       (i_req.block_size),
        .o_status     (o_rsp.status),
        .o_found_addr (o_rsp.found_addr),
        .o_found_size (o_rsp.found_size)
    );

endmodule

`default_nettype wire

@@ rtl/ssfl_ctrl.sv @@
// ============================================================================
// ssfl_ctrl
// sequencer: request capture, compare, commit and response valid
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssfl_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output ssfl_pkg::t_cmd    o_cmd
);

    ssfl_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             can_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ssfl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        can_fin      = !r_out_valid || i_out_ready;
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        unique case (r_state)
            ssfl_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ssfl_pkg::S_CMP;
                end
            end
            ssfl_pkg::S_CMP: begin
                o_cmd.cmp_en = 1'b1;
                n_state      = ssfl_pkg::S_UPD;
            end
            ssfl_pkg::S_UPD: begin
                if (can_fin) begin
                    o_cmd.commit = 1'b1;
                    o_in_ready   = 1'b1;
                    n_state      = i_in_valid ? ssfl_pkg::S_CMP : ssfl_pkg::S_IDLE;
                end
            end
            default: n_state = ssfl_pkg::S_IDLE;
        endcase
        o_cmd.load_req = o_in_ready && i_in_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/ssfl_dpath.sv @@
// ============================================================================
// ssfl_dpath
// row of entry cells with per-cell compare flags, shift and result register
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssfl_dpath #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire ssfl_pkg::t_cmd           i_cmd,
    input  wire [ssfl_pkg::FUNC_W-1:0]    i_func,
    input  wire [ssfl_pkg::WORD_W-1:0]    i_addr,
    input  wire [ssfl_pkg::WORD_W-1:0]    i_size,
    output logic [ssfl_pkg::STAT_W-1:0]   o_status,
    output logic [ssfl_pkg::WORD_W-1:0]   o_found_addr,
    output logic [ssfl_pkg::WORD_W-1:0]   o_found_size
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned LV = $clog2(DEPTH);

    logic [ssfl_pkg::FUNC_W-1:0] r_func;
    logic [ssfl_pkg::WORD_W-1:0] r_addr;
    logic [ssfl_pkg::WORD_W-1:0] r_size;

    logic [ssfl_pkg::WORD_W-1:0] r_ent_addr [DEPTH];
    logic [ssfl_pkg::WORD_W-1:0] r_ent_size [DEPTH];
    logic [ssfl_pkg::WORD_W-1:0] n_ent_addr [DEPTH];
    logic [ssfl_pkg::WORD_W-1:0] n_ent_size [DEPTH];
    logic [CW-1:0]               r_count, n_count;

    logic [DEPTH-1:0] r_cand, r_match, r_hit;
    logic [DEPTH-1:0] valid_c, cand_c, match_c, hit_c;
    logic [DEPTH-1:0] pre [LV+1];
    logic [DEPTH-1:0] first;

    logic [ssfl_pkg::STAT_W-1:0] r_status, n_status;
    logic [ssfl_pkg::WORD_W-1:0] r_faddr, n_faddr;
    logic [ssfl_pkg::WORD_W-1:0] r_fsize, n_fsize;
    logic [ssfl_pkg::WORD_W-1:0] sel_addr, sel_size;
    logic                        is_full;

    // per-cell compares
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            valid_c[i] = CW'(i) < r_count;
            cand_c[i]  = !valid_c[i] || (r_ent_size[i] >= r_size);
            match_c[i] = valid_c[i] && (r_ent_addr[i] == r_addr);
            hit_c[i]   = valid_c[i] && (r_ent_size[i] >= r_size);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_func <= i_func;
            r_addr <= i_addr;
            r_size <= i_size;
        end
        if (i_cmd.cmp_en) begin
            r_cand  <= cand_c;
            r_match <= match_c;
            r_hit   <= hit_c;
        end
    end

    // prefix or of address matches, log depth
    always_comb begin
        pre[0] = r_match;
        for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << l)) begin
                    pre[l+1][i] = pre[l][i] | pre[l][i - (1 << l)];
                end else begin
                    pre[l+1][i] = pre[l][i];
                end
            end
        end
    end

    // first covering entry and its fields
    always_comb begin
        sel_addr = '0;
        sel_size = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                first[i] = r_hit[i];
            end else begin
                first[i] = r_hit[i] && !r_hit[i-1];
            end
            sel_addr = sel_addr | (r_ent_addr[i] & {ssfl_pkg::WORD_W{first[i]}});
            sel_size = sel_size | (r_ent_size[i] & {ssfl_pkg::WORD_W{first[i]}});
        end
    end

    always_comb begin
        is_full  = r_count == CW'(DEPTH);
        n_count  = r_count;
        n_status = ssfl_pkg::ST_MISS;
        n_faddr  = '0;
        n_fsize  = '0;
        for (int i = 0; i < DEPTH; i++) begin
            n_ent_addr[i] = r_ent_addr[i];
            n_ent_size[i] = r_ent_size[i];
        end
        case (r_func)
            ssfl_pkg::FN_INSERT: begin
                if (is_full) begin
                    n_status = ssfl_pkg::ST_FULL;
                end else begin
                    n_status = ssfl_pkg::ST_OK;
                    n_count  = r_count + CW'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (i > 0 && r_cand[(i > 0) ? i-1 : 0]) begin
                            n_ent_addr[i] = r_ent_addr[(i > 0) ? i-1 : 0];
                            n_ent_size[i] = r_ent_size[(i > 0) ? i-1 : 0];
                        end else if (r_cand[i]) begin
                            n_ent_addr[i] = r_addr;
                            n_ent_size[i] = r_size;
                        end
                    end
                end
            end
            ssfl_pkg::FN_REMOVE: begin
                if (pre[LV][DEPTH-1]) begin
                    n_status = ssfl_pkg::ST_OK;
                    n_count  = r_count - CW'(1);
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (pre[LV][i]) begin
                            n_ent_addr[i] = r_ent_addr[i+1];
                            n_ent_size[i] = r_ent_size[i+1];
                        end
                    end
                end
            end
            ssfl_pkg::FN_FIND: begin
                if (|r_hit) begin
                    n_status = ssfl_pkg::ST_OK;
                    n_faddr  = sel_addr;
                    n_fsize  = sel_size;
                end
            end
            default: n_status = ssfl_pkg::ST_MISS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_ent_addr[i] <= n_ent_addr[i];
                r_ent_size[i] <= n_ent_size[i];
            end
            r_status <= n_status;
            r_faddr  <= n_faddr;
            r_fsize  <= n_fsize;
        end
    end

    assign o_status     = r_status;
    assign o_found_addr = r_faddr;
    assign o_found_size = r_fsize;

endmodule

`default_nettype wire

@@ rtl/ssfl_checker.sv @@
// ============================================================================
// ssfl_checker
// port level checks on the free list handshake and response timing
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssfl_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          i_in_valid,
    input wire                          i_in_ready,
    input wire                          i_out_valid,
    input wire                          i_out_ready,
    input wire [ssfl_pkg::STAT_W-1:0]   i_status,
    input wire [ssfl_pkg::WORD_W-1:0]   i_found_addr,
    input wire [ssfl_pkg::WORD_W-1:0]   i_found_size
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken during compare cycle");

    a_rsp_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |-> ##3 i_out_valid)
        else $error("no response three cycles after request");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("response valid after reset");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ssfl_pkg::ST_OK |->
            i_found_addr == '0 && i_found_size == '0)
        else $error("nonzero fields on a failed operation");

endmodule

bind size_sorted_free_list ssfl_checker u_ssfl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_found_addr (o_rsp.found_addr),
    .i_found_size (o_rsp.found_size)
);

`default_nettype wire
